// File: rtl/core/scbt_pkg.sv
// Shared types and defaults for the segment versus circle-boundary test.
// Used by scbt_sq_cmp, segment_circle_boundary_test_unit and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package scbt_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  typedef struct packed {
    logic foot_in;
    logic far_ok;
    logic near_ep;
  } scbt_flags_t;

  typedef struct packed {
    logic mul;
    logic grp;
    logic add;
  } scbt_adv_t;

endpackage

`default_nettype wire

// File: rtl/core/segment_circle_boundary_test_unit.sv
// Top level of the segment versus circle-boundary crossing test.
// Depends on scbt_pkg and instantiates scbt_sq_cmp.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one segment and circle per cycle while in_stall is low and
// returns one result beat per input beat, in order. The pipeline holds two
// multiplier levels, one for the coordinate products and one for the split
// wide products of the squared compare, with their adds in between.
// A stall on the output fills bubbles first and then holds the input.

module segment_circle_boundary_test_unit
  import scbt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_y,
  input  wire logic        [COORD_WIDTH-1:0] in_radius,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_collide,
  output logic                               out_foot_inside
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;
  localparam int MW = 2 * W + 2;
  localparam int NS = 8;
  localparam int ST_DIFF = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_CMP  = 3;
  localparam int ST_SQM  = 4;
  localparam int ST_GRP  = 5;
  localparam int ST_ADD  = 6;
  localparam int ST_OUT  = 7;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] en;

  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic        [W-1:0]  rad_r;

  logic signed [PW-1:0] aa_r, ayy_r, bb_r, byy_r;
  logic signed [PW-1:0] adx_r, ady_r, bdx_r, bdy_r;
  logic signed [PW-1:0] aby_r, ayb_r, dxx_r, dyy_r;
  logic        [2*W-1:0] r2_r;

  logic signed [SW-1:0] dp_r, dq_r, d1n_r, d2_r, cross_r, len2_r;
  logic        [2*W-1:0] r2s_r;

  scbt_flags_t          flags_nxt, flags_r;
  logic        [MW-1:0] cmag_nxt, cmag_r, len2q_r, r2q_r;

  scbt_adv_t            adv;
  scbt_flags_t          flags_late;
  logic                 perp_ok;

  logic                 collide_nxt, collide_r, foot_r;

  always_comb begin
    en[NS-1] = !valid_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[ST_DIFF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      ax_r  <= DW'(in_seg_start_x) - DW'(in_center_x);
      ay_r  <= DW'(in_seg_start_y) - DW'(in_center_y);
      bx_r  <= DW'(in_seg_end_x) - DW'(in_center_x);
      by_r  <= DW'(in_seg_end_y) - DW'(in_center_y);
      dx_r  <= DW'(in_seg_end_x) - DW'(in_seg_start_x);
      dy_r  <= DW'(in_seg_end_y) - DW'(in_seg_start_y);
      rad_r <= in_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      aa_r  <= ax_r * ax_r;
      ayy_r <= ay_r * ay_r;
      bb_r  <= bx_r * bx_r;
      byy_r <= by_r * by_r;
      adx_r <= ax_r * dx_r;
      ady_r <= ay_r * dy_r;
      bdx_r <= bx_r * dx_r;
      bdy_r <= by_r * dy_r;
      aby_r <= ax_r * by_r;
      ayb_r <= ay_r * bx_r;
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      r2_r  <= rad_r * rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      dp_r    <= SW'(aa_r) + SW'(ayy_r);
      dq_r    <= SW'(bb_r) + SW'(byy_r);
      d1n_r   <= SW'(adx_r) + SW'(ady_r);
      d2_r    <= SW'(bdx_r) + SW'(bdy_r);
      cross_r <= SW'(aby_r) - SW'(ayb_r);
      len2_r  <= SW'(dxx_r) + SW'(dyy_r);
      r2s_r   <= r2_r;
    end
  end

  // The first dot product is the negation of the stored sum, so it is positive
  // when that sum is negative.
  always_comb begin
    flags_nxt.foot_in = d1n_r[SW-1] && !d2_r[SW-1] && (|d2_r);
    flags_nxt.far_ok  = ($unsigned(dp_r) >= SW'(r2s_r)) || ($unsigned(dq_r) >= SW'(r2s_r));
    flags_nxt.near_ep = ($unsigned(dp_r) <= SW'(r2s_r)) || ($unsigned(dq_r) <= SW'(r2s_r));
    cmag_nxt          = cross_r[SW-1] ? MW'(-cross_r) : MW'(cross_r);
  end

  always_ff @(posedge clk) begin
    if (en[ST_CMP]) begin
      flags_r <= flags_nxt;
      cmag_r  <= cmag_nxt;
      len2q_r <= MW'($unsigned(len2_r));
      r2q_r   <= MW'(r2s_r);
    end
  end

  assign adv.mul = en[ST_SQM];
  assign adv.grp = en[ST_GRP];
  assign adv.add = en[ST_ADD];

  scbt_sq_cmp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sq_cmp (
    .clk       (clk),
    .adv       (adv),
    .flags_in  (flags_r),
    .cmag      (cmag_r),
    .len2      (len2q_r),
    .r2        (r2q_r),
    .flags_out (flags_late),
    .perp_ok   (perp_ok)
  );

  assign collide_nxt = (flags_late.foot_in ? perp_ok : flags_late.near_ep) && flags_late.far_ok;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      collide_r <= collide_nxt;
      foot_r    <= flags_late.foot_in;
    end
  end

  assign out_valid       = valid_r[ST_OUT];
  assign out_collide     = collide_r;
  assign out_foot_inside = foot_r;

`ifndef NO_ASSERTIONS
  a_full_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((&valid_r) && out_stall) |-> in_stall)
    else $error("full pipeline under output stall did not stall the input");

  a_bubble_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[ST_DIFF] |-> !in_stall)
    else $error("empty first stage stalled the input");

  a_late_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[ST_ADD] && en[ST_OUT]) |=> out_valid)
    else $error("beat leaving the last compare stage was lost");

  a_stalled_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[ST_SUM] && !en[ST_CMP]) |=> valid_r[ST_SUM])
    else $error("stalled beat dropped from the sum stage");
`endif

endmodule

`default_nettype wire

// File: rtl/core/scbt_sq_cmp.sv
// Pipelined exact compare of cross^2 against r^2 * len2, three register stages.
// Depends on scbt_pkg for the flag and stage-advance types.
`timescale 1ns / 1ps
`default_nettype none

module scbt_sq_cmp
  import scbt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire scbt_adv_t                     adv,
  input  wire scbt_flags_t                   flags_in,
  input  wire logic [2*COORD_WIDTH+1:0]      cmag,
  input  wire logic [2*COORD_WIDTH+1:0]      len2,
  input  wire logic [2*COORD_WIDTH+1:0]      r2,
  output scbt_flags_t                        flags_out,
  output logic                               perp_ok
);

  localparam int HW  = COORD_WIDTH + 1;
  localparam int MW  = 2 * HW;
  localparam int PW  = 2 * HW;
  localparam int MRW = PW + 1;
  localparam int QW  = 4 * HW;

  logic [HW-1:0] ch, cl, rh, rl, lh, ll;

  logic [PW-1:0]  hh_r, hl_r, lo_r;
  logic [PW-1:0]  rhlh_r, rhll_r, rllh_r, rlll_r;
  scbt_flags_t    flags5_r, flags6_r, flags7_r;

  logic [QW-1:0]  ac_r, ar_r;
  logic [PW-1:0]  mc_r;
  logic [MRW-1:0] mr_r;

  logic [QW-1:0]  cr2_r, rr_r;

  assign ch = cmag[MW-1:HW];
  assign cl = cmag[HW-1:0];
  assign rh = r2[MW-1:HW];
  assign rl = r2[HW-1:0];
  assign lh = len2[MW-1:HW];
  assign ll = len2[HW-1:0];

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      hh_r     <= ch * ch;
      hl_r     <= ch * cl;
      lo_r     <= cl * cl;
      rhlh_r   <= rh * lh;
      rhll_r   <= rh * ll;
      rllh_r   <= rl * lh;
      rlll_r   <= rl * ll;
      flags5_r <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.grp) begin
      ac_r     <= {hh_r, lo_r};
      mc_r     <= hl_r;
      ar_r     <= {rhlh_r, rlll_r};
      mr_r     <= MRW'(rhll_r) + MRW'(rllh_r);
      flags6_r <= flags5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.add) begin
      cr2_r    <= ac_r + (QW'(mc_r) << (HW + 1));
      rr_r     <= ar_r + (QW'(mr_r) << HW);
      flags7_r <= flags6_r;
    end
  end

  assign perp_ok   = (cr2_r <= rr_r);
  assign flags_out = flags7_r;

endmodule

`default_nettype wire

// File: verif/tb_segment_circle_boundary_test_unit.sv
// Self-checking testbench for segment_circle_boundary_test_unit: directed and random
// segment/circle queries with random stalls on both channels, checked against an exact predictor.
// Depends on scbt_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_segment_circle_boundary_test_unit;
  import scbt_pkg::*;

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic signed [COORD_WIDTH-1:0] ex;
    logic signed [COORD_WIDTH-1:0] ey;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic        [COORD_WIDTH-1:0] r;
  } query_t;

  typedef struct packed {
    logic collide;
    logic foot_inside;
  } verdict_t;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_WIDTH-1:0] in_seg_start_x = '0;
  logic signed [COORD_WIDTH-1:0] in_seg_start_y = '0;
  logic signed [COORD_WIDTH-1:0] in_seg_end_x = '0;
  logic signed [COORD_WIDTH-1:0] in_seg_end_y = '0;
  logic signed [COORD_WIDTH-1:0] in_center_x = '0;
  logic signed [COORD_WIDTH-1:0] in_center_y = '0;
  logic        [COORD_WIDTH-1:0] in_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_collide;
  logic out_foot_inside;

  query_t   pending_queries[$];
  verdict_t expected_verdicts[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  logic     hold_start = 1'b0;
  int       hold_left = 0;

  segment_circle_boundary_test_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_collide    (out_collide),
    .out_foot_inside(out_foot_inside)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t judge_crossing(query_t q);
    wide_t px, py, qx, qy, ox, oy, rr;
    wide_t r2, dp, dq, d1, d2, cr, len2;
    logic foot_in, far_ok, near_ok;
    verdict_t v;
    px = $signed(q.sx);
    py = $signed(q.sy);
    qx = $signed(q.ex);
    qy = $signed(q.ey);
    ox = $signed(q.cx);
    oy = $signed(q.cy);
    rr = q.r;
    r2 = rr * rr;
    dp = (px - ox) * (px - ox) + (py - oy) * (py - oy);
    dq = (qx - ox) * (qx - ox) + (qy - oy) * (qy - oy);
    d1 = (px - ox) * (px - qx) + (py - oy) * (py - qy);
    d2 = (qx - ox) * (qx - px) + (qy - oy) * (qy - py);
    foot_in = (d1 > 0) && (d2 > 0);
    far_ok = (dp >= r2) || (dq >= r2);
    if (foot_in) begin
      cr = (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
      len2 = (qx - px) * (qx - px) + (qy - py) * (qy - py);
      near_ok = (cr * cr) <= (r2 * len2);
    end else begin
      near_ok = (dp <= r2) || (dq <= r2);
    end
    v.collide = near_ok && far_ok;
    v.foot_inside = foot_in;
    return v;
  endfunction

  function automatic query_t make_query(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    query_t q;
    q.sx = COORD_WIDTH'(sx);
    q.sy = COORD_WIDTH'(sy);
    q.ex = COORD_WIDTH'(ex);
    q.ey = COORD_WIDTH'(ey);
    q.cx = COORD_WIDTH'(cx);
    q.cy = COORD_WIDTH'(cy);
    q.r  = COORD_WIDTH'(r);
    return q;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic query_t random_query();
    logic [127:0] bits;
    int bx, by, y0, rad, cyv, t;
    query_t q;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        bits = {$urandom, $urandom, $urandom, $urandom};
        q = bits[$bits(query_t)-1:0];
      end
      3, 4, 5: begin
        bx = spread(-30000, 30000);
        by = spread(-30000, 30000);
        q = make_query(bx + spread(-40, 40), by + spread(-40, 40), bx + spread(-40, 40),
                       by + spread(-40, 40), bx + spread(-40, 40), by + spread(-40, 40),
                       spread(0, 60));
      end
      6, 7: begin
        // Segment on an axis with the circle touching, just reaching or just missing it.
        y0 = spread(-20000, 20000);
        rad = spread(0, 12000);
        cyv = y0 + (($urandom_range(0, 1) != 0) ? rad : -rad) + spread(-1, 1);
        q = make_query(spread(-20000, 20000), y0, spread(-20000, 20000), y0,
                       spread(-20000, 20000), cyv, rad);
        if ($urandom_range(0, 1) != 0) begin
          q = '{sx: q.sy, sy: q.sx, ex: q.ey, ey: q.ex, cx: q.cy, cy: q.cx, r: q.r};
        end
      end
      8: begin
        bx = spread(-30000, 30000);
        by = spread(-30000, 30000);
        t = spread(0, 60);
        q = make_query(bx, by, bx, by, bx + spread(-t, t), by + spread(-t, t), spread(0, 90));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: rad = 0;
          1: rad = 65535;
          default: rad = spread(0, 65535);
        endcase
        q = make_query(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                       edge_coord(), edge_coord(), rad);
      end
    endcase
    return q;
  endfunction

  task automatic add_query(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    pending_queries.push_back(make_query(sx, sy, ex, ey, cx, cy, r));
  endtask

  task automatic add_random(int count);
    repeat (count) pending_queries.push_back(random_query());
  endtask

  task automatic wait_drained(bit all_results);
    while (pending_queries.size() != 0 || (all_results && expected_verdicts.size() != 0))
      @(negedge clk);
  endtask

  task automatic flag_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // A new beat is offered only once the current one has been taken.
  always @(posedge clk) begin : drive_beats
    query_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        q = pending_queries.pop_front();
        expected_verdicts.push_back(judge_crossing(q));
        in_seg_start_x <= q.sx;
        in_seg_start_y <= q.sy;
        in_seg_end_x   <= q.ex;
        in_seg_end_y   <= q.ey;
        in_center_x    <= q.cx;
        in_center_y    <= q.cy;
        in_radius      <= q.r;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = expected_verdicts.pop_front();
        if (out_collide !== want.collide)
          flag_mismatch($sformatf("collide %b, expected %b", out_collide, want.collide));
        if (out_foot_inside !== want.foot_inside)
          flag_mismatch($sformatf("foot_inside %b, expected %b", out_foot_inside,
                                  want.foot_inside));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_segment_circle_boundary_test_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 32;
    recv_idle = 66;
    add_query(0, 0, 0, 0, 0, 0, 0);
    add_query(3, 4, 3, 4, 0, 0, 5);
    add_query(5, 5, 5, 5, 0, 0, 5);
    add_query(-10, 0, 10, 0, 3, 0, 0);
    add_query(-10, 0, 10, 0, 3, 1, 0);
    add_query(-10, 5, 10, 5, 0, 0, 5);
    add_query(-10, 5, 10, 5, 0, 0, 4);
    add_query(-1, 0, 1, 0, 0, 0, 10);
    add_query(0, 0, 10, 0, 0, 0, 10);
    add_query(10, 0, 20, 0, 0, 3, 12);
    add_query(1, 1, 2, 2, 3, 3, 1);
    add_query(-32768, -32768, 32767, 32767, -32768, 32767, 65535);
    add_query(32767, -32768, -32768, 32767, 32767, 32767, 0);
    add_query(-32768, -32768, -32768, -32768, 32767, 32767, 65535);
    add_query(32767, 32767, -32768, -32768, 0, 0, 65535);
    add_query(-32768, 0, 32767, 0, 0, -32768, 32768);
    add_query(-32768, 32767, 32767, 32767, 0, -32768, 65535);
    add_query(-32768, 32767, 32767, 32767, 0, -32768, 65534);
    add_query(32767, 32767, 32767, -32768, -32768, -32768, 65535);
    add_random(620);
    wait_drained(1'b0);

    // Long output hold while beats keep coming, so the pipeline backs up into in_stall.
    send_idle = 0;
    recv_idle = 0;
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    add_random(60);
    wait_drained(1'b1);

    send_idle = 66;
    recv_idle = 32;
    add_random(580);
    wait_drained(1'b0);

    send_idle = 0;
    recv_idle = 0;
    add_random(590);
    wait_drained(1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("tb_segment_circle_boundary_test_unit OK");
    end else begin
      $display("tb_segment_circle_boundary_test_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/scbt_pkg.sv
rtl/core/scbt_sq_cmp.sv
rtl/core/segment_circle_boundary_test_unit.sv
verif/tb_segment_circle_boundary_test_unit.sv
